>>> rtl/srvp_pkg.sv
// Shared constants for the SNMP response value parser.
package srvp_pkg;

   // Default parameter values
   localparam int DEFAULT_MAX_LENGTH_BYTES = 4;
   localparam int DEFAULT_MAX_VALUE_BYTES  = 5;

   // BER tags
   localparam logic [7:0] TAG_INTEGER    = 8'h02;
   localparam logic [7:0] TAG_OID        = 8'h06;
   localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
   localparam logic [7:0] TAG_COUNTER32  = 8'h41;
   localparam logic [7:0] TAG_GAUGE32    = 8'h42;
   localparam logic [7:0] TAG_TIMETICKS  = 8'h43;
   localparam logic [7:0] TAG_COUNTER64  = 8'h46;

   // Tag class selection for PDU containers
   localparam logic [7:0] CLASS_MASK     = 8'he0;
   localparam logic [7:0] CLASS_CONTEXT  = 8'ha0;

   // Length byte fields
   localparam logic [6:0] LEN_COUNT_MASK = 7'h7f;
   localparam int         LEN_LONG_BIT   = 7;

endpackage

>>> rtl/srvp_if.sv
// Request and response channel interfaces of the SNMP response value parser.
interface srvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface srvp_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [31:0] value;

   modport source (output valid, output found, output value, input ready);
   modport sink   (input valid, input found, input value, output ready);
endinterface

>>> rtl/snmp_response_value_parser_top.sv
// SNMP response value parser: streams packet bytes and reports the value after the first OID.
//
// The request channel carries one packet byte per request with end_of_packet on the
// final byte. The parser walks BER items, enters SEQUENCE and context-class PDU
// items, skips the rest, and after the first OID reads one numeric value.
// Exactly one response comes per packet: found and value, issued from the
// output register in the cycle after the request that carries end_of_packet.
// Bytes without end_of_packet produce no response.
// Throughput is one request per cycle while req ready is high: each byte passes
// through one tag/length state update, and the output register parts the two sides.
// While a response waits in the output register and the receiver holds ready
// low, req ready drops; the request stalls until the response is taken.
// A response taken in the same cycle frees the register for the next one.
// Reset (synchronous, active high) returns the parser to expect a tag and
// empties the output register. After every end_of_packet the parse state
// returns to its reset value.
module snmp_response_value_parser_top #(
   parameter int MAX_LENGTH_BYTES = srvp_pkg::DEFAULT_MAX_LENGTH_BYTES,
   parameter int MAX_VALUE_BYTES  = srvp_pkg::DEFAULT_MAX_VALUE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   srvp_req_if.sink   req_chan,
   srvp_rsp_if.source rsp_chan
);
   import srvp_pkg::*;

   localparam int LCW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int VCW = $clog2(MAX_VALUE_BYTES + 1);

   // Parse phases
   localparam logic [3:0] PH_TAG        = 4'd0;
   localparam logic [3:0] PH_LEN_FIRST  = 4'd1;
   localparam logic [3:0] PH_LEN_MORE   = 4'd2;
   localparam logic [3:0] PH_SKIP       = 4'd3;
   localparam logic [3:0] PH_OID_SKIP   = 4'd4;
   localparam logic [3:0] PH_VTAG       = 4'd5;
   localparam logic [3:0] PH_VLEN_FIRST = 4'd6;
   localparam logic [3:0] PH_VLEN_MORE  = 4'd7;
   localparam logic [3:0] PH_VAL_FIRST  = 4'd8;
   localparam logic [3:0] PH_VAL_REST   = 4'd9;
   localparam logic [3:0] PH_DONE       = 4'd10;

   logic [3:0]         phase_ff, phase_in;
   logic [7:0]         item_tag_ff, item_tag_in;
   logic [LCW-1:0]     len_left_ff, len_left_in;
   logic [31:0]        len_accum_ff, len_accum_in;
   logic [31:0]        skip_left_ff, skip_left_in;
   logic               is_signed_ff, is_signed_in;
   logic [VCW-1:0]     val_left_ff, val_left_in;
   logic [31:0]        val_accum_ff, val_accum_in;
   logic               found_ff, found_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;

   logic               accept;
   logic [7:0]         b;
   logic [6:0]         len_count;
   logic [31:0]        accum_shift;
   logic               outer_done;
   logic [31:0]        outer_len;
   logic               value_done;
   logic [31:0]        value_len;
   logic               fail;

   // Accept while the output register is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign len_count      = b[6:0] & LEN_COUNT_MASK;
   assign accum_shift    = {len_accum_ff[23:0], b};

   // Advance the parse state by one byte
   always_comb begin
      phase_in     = phase_ff;
      item_tag_in  = item_tag_ff;
      len_left_in  = len_left_ff;
      len_accum_in = len_accum_ff;
      skip_left_in = skip_left_ff;
      is_signed_in = is_signed_ff;
      val_left_in  = val_left_ff;
      val_accum_in = val_accum_ff;
      found_in     = found_ff;
      outer_done   = 1'b0;
      outer_len    = '0;
      value_done   = 1'b0;
      value_len    = '0;
      fail         = 1'b0;

      case (phase_ff)
         PH_TAG: begin
            item_tag_in = b;
            phase_in    = PH_LEN_FIRST;
         end
         PH_LEN_FIRST, PH_VLEN_FIRST: begin
            if (!b[LEN_LONG_BIT]) begin
               if (phase_ff == PH_LEN_FIRST) begin
                  outer_done = 1'b1;
                  outer_len  = {24'd0, b};
               end else begin
                  value_done = 1'b1;
                  value_len  = {24'd0, b};
               end
            end else if (len_count == 7'd0 || len_count > 7'(MAX_LENGTH_BYTES)) begin
               fail = 1'b1;
            end else begin
               len_left_in  = LCW'(len_count);
               len_accum_in = '0;
               phase_in     = (phase_ff == PH_LEN_FIRST) ? PH_LEN_MORE : PH_VLEN_MORE;
            end
         end
         PH_LEN_MORE, PH_VLEN_MORE: begin
            len_accum_in = accum_shift;
            len_left_in  = len_left_ff - LCW'(1);
            if (len_left_ff == LCW'(1)) begin
               if (phase_ff == PH_LEN_MORE) begin
                  outer_done = 1'b1;
                  outer_len  = accum_shift;
               end else begin
                  value_done = 1'b1;
                  value_len  = accum_shift;
               end
            end
         end
         PH_SKIP, PH_OID_SKIP: begin
            skip_left_in = skip_left_ff - 32'd1;
            if (skip_left_ff == 32'd1) begin
               phase_in = (phase_ff == PH_SKIP) ? PH_TAG : PH_VTAG;
            end
         end
         PH_VTAG: begin
            if (b == TAG_INTEGER) begin
               is_signed_in = 1'b1;
               phase_in     = PH_VLEN_FIRST;
            end else if (b == TAG_COUNTER32 || b == TAG_GAUGE32 ||
                         b == TAG_TIMETICKS || b == TAG_COUNTER64) begin
               is_signed_in = 1'b0;
               phase_in     = PH_VLEN_FIRST;
            end else begin
               fail = 1'b1;
            end
         end
         PH_VAL_FIRST, PH_VAL_REST: begin
            if (phase_ff == PH_VAL_REST) begin
               val_accum_in = {val_accum_ff[23:0], b};
            end else if (is_signed_ff && b[7]) begin
               val_accum_in = {24'hffffff, b};
            end else begin
               val_accum_in = {24'd0, b};
            end
            val_left_in = val_left_ff - VCW'(1);
            if (val_left_ff == VCW'(1)) begin
               found_in = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_VAL_REST;
            end
         end
         default: begin
         end
      endcase

      // Route on a completed item length
      if (outer_done) begin
         if (item_tag_ff == TAG_OID) begin
            if (outer_len == 32'd0) begin
               phase_in = PH_VTAG;
            end else begin
               skip_left_in = outer_len;
               phase_in     = PH_OID_SKIP;
            end
         end else if (item_tag_ff == TAG_SEQUENCE ||
                      (item_tag_ff & CLASS_MASK) == CLASS_CONTEXT) begin
            phase_in = PH_TAG;
         end else if (outer_len == 32'd0) begin
            phase_in = PH_TAG;
         end else begin
            skip_left_in = outer_len;
            phase_in     = PH_SKIP;
         end
      end

      // Check a completed value length
      if (value_done) begin
         if (value_len == 32'd0 || value_len > 32'(MAX_VALUE_BYTES)) begin
            fail = 1'b1;
         end else begin
            val_left_in = VCW'(value_len);
            phase_in    = PH_VAL_FIRST;
         end
      end

      if (fail) begin
         phase_in = PH_DONE;
      end
   end

   // Load the response on the final byte, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_chan.end_of_packet) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_in;
         rsp_value_in = found_in ? val_accum_in : '0;
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.end_of_packet)) begin
         phase_ff     <= PH_TAG;
         item_tag_ff  <= '0;
         len_left_ff  <= '0;
         len_accum_ff <= '0;
         skip_left_ff <= '0;
         is_signed_ff <= 1'b0;
         val_left_ff  <= '0;
         val_accum_ff <= '0;
         found_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         item_tag_ff  <= item_tag_in;
         len_left_ff  <= len_left_in;
         len_accum_ff <= len_accum_in;
         skip_left_ff <= skip_left_in;
         is_signed_ff <= is_signed_in;
         val_left_ff  <= val_left_in;
         val_accum_ff <= val_accum_in;
         found_ff     <= found_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.found = rsp_found_ff;
   assign rsp_chan.value = rsp_value_ff;

endmodule
